@@ src/tsem_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsem_pkg
// Types and constants shared by the train search event matcher modules.
// ----------------------------------------------------------------------------
package tsem_pkg;

  localparam int unsigned EVENT_W  = 64;
  localparam int unsigned PREFIX_W = 32;
  localparam int unsigned ADDR_W   = 14;
  localparam int unsigned SADDR_W  = 16;
  localparam int unsigned NIBBLES  = 6;
  localparam int unsigned TDIGITS  = 5;

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    CFG_TRAIN_ADDRESS       = 2'd0,
    CFG_LONG_ADDRESS_MODE   = 2'd1,
    CFG_SHORT_ADDRESS_LIMIT = 2'd2,
    CFG_SEARCH_SPACE_PREFIX = 2'd3
  } cfg_reg_t;

  localparam logic [ADDR_W-1:0]   LIMIT_RESET  = 14'd128;
  localparam logic [PREFIX_W-1:0] PREFIX_RESET = 32'h0900_99FF;

  // Flags byte bit positions
  localparam int unsigned FLAG_ALLOCATE = 7;
  localparam int unsigned FLAG_EXACT    = 6;
  localparam int unsigned FLAG_RESERVED = 4;
  localparam int unsigned FLAG_DCC      = 3;
  localparam int unsigned FLAG_LONG     = 2;

  // Query nibble codes
  localparam logic [3:0] NIB_DEC_MAX = 4'h9;
  localparam logic [3:0] NIB_RSV_LO  = 4'hA;
  localparam logic [3:0] NIB_RSV_HI  = 4'hE;

  // floor(v / 100) = (v * 5243) >> 19 for every 14-bit v
  localparam logic [12:0] RECIP_100    = 13'd5243;
  localparam int unsigned RECIP_100_SH = 19;
  // floor(v / 10) = (v * 205) >> 11 for v below 1029
  localparam int unsigned RECIP_10_SH  = 11;

  typedef struct packed {
    logic [ADDR_W-1:0]   loco_addr;
    logic [7:0]          addr_div100;
    logic                long_mode;
    logic [ADDR_W-1:0]   short_limit;
    logic [PREFIX_W-1:0] prefix;
  } cfg_t;

  typedef struct packed {
    logic [NIBBLES-1:0][3:0] digits;   // compacted search digits, first at [0]
    logic [2:0]              count;
    logic [SADDR_W-1:0]      saddr;
    logic                    nib_reject;
  } query_t;

  typedef struct packed {
    logic [TDIGITS-1:0][3:0] digits;   // decimal digits, most significant at [0]
    logic [2:0]              count;
  } tdigits_t;

endpackage

@@ src/tsem_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsem_cfg
// Configuration registers; also keeps the node address / 100 alongside it.
// ----------------------------------------------------------------------------
module tsem_cfg
  import tsem_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output cfg_t        cfg
);

  cfg_t        cfg_r;
  cfg_t        cfg_nxt;
  logic [26:0] div_prod;

  assign div_prod = {13'b0, cfg_data[ADDR_W-1:0]} * {14'b0, RECIP_100};

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_TRAIN_ADDRESS: begin
          cfg_nxt.loco_addr   = cfg_data[ADDR_W-1:0];
          cfg_nxt.addr_div100 = div_prod[RECIP_100_SH +: 8];
        end
        CFG_LONG_ADDRESS_MODE:   cfg_nxt.long_mode   = cfg_data[0];
        CFG_SHORT_ADDRESS_LIMIT: cfg_nxt.short_limit = cfg_data[ADDR_W-1:0];
        CFG_SEARCH_SPACE_PREFIX: cfg_nxt.prefix      = cfg_data[PREFIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.loco_addr     <= '0;
      cfg_r.addr_div100   <= '0;
      cfg_r.long_mode     <= 1'b0;
      cfg_r.short_limit   <= LIMIT_RESET;
      cfg_r.prefix        <= PREFIX_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ src/tsem_query.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsem_query
// Decodes the six query nibbles: digits, digit count, search address.
// ----------------------------------------------------------------------------
module tsem_query
  import tsem_pkg::*;
(
  input  logic [23:0] nibbles,
  output query_t      query
);

  always_comb begin
    logic [3:0] nib;
    query = '0;
    for (int i = 0; i < NIBBLES; i++) begin
      nib = nibbles[23 - 4*i -: 4];
      if (nib inside {[NIB_RSV_LO:NIB_RSV_HI]}) begin
        query.nib_reject = 1'b1;
      end
      if (nib <= NIB_DEC_MAX) begin
        query.digits[query.count] = nib;
        query.count = query.count + 3'd1;
        // wraps at 16 bits
        query.saddr = SADDR_W'(query.saddr * 16'd10 + {12'b0, nib});
      end
    end
  end

endmodule

@@ src/tsem_tdigits.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsem_tdigits
// Splits the train address into decimal digits, most significant first.
// ----------------------------------------------------------------------------
module tsem_tdigits
  import tsem_pkg::*;
(
  input  logic [ADDR_W-1:0] addr,
  input  logic [7:0]        addr_div100,
  output tdigits_t          tdig
);

  logic [ADDR_W-1:0]        hund_part;
  logic [6:0]               rem100;
  logic [14:0]              m_tens;
  logic [15:0]              m_thou;
  logic [3:0]               d_tens;
  logic [4:0]               div1000;
  logic                     d_tth;
  logic [TDIGITS-1:0][3:0]  dig;   // units at [0]

  assign hund_part = ADDR_W'({6'b0, addr_div100} * 14'd100);
  assign rem100    = 7'(addr - hund_part);
  assign m_tens    = {8'b0, rem100} * 15'd205;
  assign d_tens    = m_tens[RECIP_10_SH +: 4];
  assign m_thou    = {8'b0, addr_div100} * 16'd205;
  assign div1000   = m_thou[RECIP_10_SH +: 5];
  assign d_tth     = (div1000 >= 5'd10);

  assign dig[0] = 4'(rem100 - 7'({3'b0, d_tens} * 7'd10));
  assign dig[1] = d_tens;
  assign dig[2] = 4'(addr_div100 - 8'({3'b0, div1000} * 8'd10));
  assign dig[3] = 4'(div1000 - (d_tth ? 5'd10 : 5'd0));
  assign dig[4] = {3'b0, d_tth};

  always_comb begin
    if (addr >= 14'd10000)     tdig.count = 3'd5;
    else if (addr >= 14'd1000) tdig.count = 3'd4;
    else if (addr >= 14'd100)  tdig.count = 3'd3;
    else if (addr >= 14'd10)   tdig.count = 3'd2;
    else                       tdig.count = 3'd1;
    for (int i = 0; i < TDIGITS; i++) begin
      if (3'(i) < tdig.count) begin
        tdig.digits[i] = dig[3'(tdig.count - 3'd1 - 3'(i))];
      end else begin
        tdig.digits[i] = 4'h0;
      end
    end
  end

endmodule

@@ src/train_search_event_matcher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// train_search_event_matcher
// Judges train search events against this node's DCC address.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_search_event and raise start; the item is taken at a
//   rising edge where start is high and busy is low. busy is high only while
//   rst_n is asserted, so one item can be taken every clock cycle.
//   Result: out_valid strobes for one cycle with the verdict of one item:
//   out_in_search_space, out_reserved_reject, out_matched and out_reply_event
//   (the event echoed when matched, zero otherwise). Results come out in
//   order, one per item; each item goes from the input register through the
//   decode logic into the result register. Throughput is one item per cycle.
//   The receiver cannot stall; each result is shown for exactly one cycle.
//   Configuration: cfg_we writes cfg_data into register cfg_index
//   (0 train address, 1 long address mode, 2 short address limit,
//   3 search space prefix). Write only while no item is in flight.
//   Reset (synchronous, rst_n low) drops any item in flight and restores
//   the register defaults: address 0, short mode, limit 128, the standard
//   train search prefix.
// ----------------------------------------------------------------------------
module train_search_event_matcher
  import tsem_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [EVENT_W-1:0]  in_search_event,
  output logic                out_valid,
  output logic                out_in_search_space,
  output logic                out_reserved_reject,
  output logic                out_matched,
  output logic [EVENT_W-1:0]  out_reply_event,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  cfg_t               cfg;
  query_t             query;
  tdigits_t           tdig;

  // input stage
  logic               vld_r;
  logic [EVENT_W-1:0] ev_r;

  // result stage
  logic               out_valid_r;
  logic               in_space_r;
  logic               reject_r;
  logic               matched_r;
  logic [EVENT_W-1:0] reply_r;

  logic               in_space_nxt;
  logic               reject_nxt;
  logic               matched_nxt;
  logic [EVENT_W-1:0] reply_nxt;

  logic [7:0]         flags;
  logic               is_short;
  logic               rule_ok;
  logic               len_ok;
  logic               digits_ok;

  // Hold off new items only while in reset
  assign busy = !rst_n;

  tsem_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tsem_query u_query (
    .nibbles (ev_r[31:8]),
    .query   (query)
  );

  tsem_tdigits u_tdigits (
    .addr        (cfg.loco_addr),
    .addr_div100 (cfg.addr_div100),
    .tdig        (tdig)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= start && !busy;
    end
  end

  // Capture the event on every accept
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      ev_r <= in_search_event;
    end
  end

  assign flags = ev_r[7:0];

  // DCC short/long address rule
  assign is_short = ({2'b0, cfg.short_limit} > query.saddr);
  always_comb begin
    rule_ok = 1'b1;
    if (flags[FLAG_DCC]) begin
      if (flags[FLAG_LONG]) begin
        rule_ok = cfg.long_mode;
      end else if (!flags[FLAG_ALLOCATE]) begin
        rule_ok = (is_short != cfg.long_mode);
      end
    end
  end

  // Search digits against the train address: exact or leading digits
  assign len_ok = (query.count != 3'd0) &&
                  (flags[FLAG_EXACT] ? (query.count == tdig.count)
                                     : (query.count <= tdig.count));

  always_comb begin
    digits_ok = 1'b1;
    for (int i = 0; i < TDIGITS; i++) begin
      if (3'(i) < query.count && query.digits[i] != tdig.digits[i]) begin
        digits_ok = 1'b0;
      end
    end
  end

  assign in_space_nxt = (ev_r[63:32] == cfg.prefix);
  assign reject_nxt   = in_space_nxt &&
                        (query.nib_reject || flags[FLAG_RESERVED] ||
                         (!flags[FLAG_DCC] && (flags[2:0] != 3'b000)));
  assign matched_nxt  = in_space_nxt && !reject_nxt && rule_ok && len_ok && digits_ok;
  assign reply_nxt    = matched_nxt ? ev_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r;
    end
  end

  // Advance the verdict into the result register
  always_ff @(posedge clk) begin
    in_space_r <= in_space_nxt;
    reject_r   <= reject_nxt;
    matched_r  <= matched_nxt;
    reply_r    <= reply_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_in_search_space = in_space_r;
  assign out_reserved_reject = reject_r;
  assign out_matched         = matched_r;
  assign out_reply_event     = reply_r;

`ifndef SYNTH
  a_strobe_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(vld_r))
    else $error("result strobe without an item in the input stage");

  a_match_needs_space: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && matched_r) |-> (in_space_r && !reject_r))
    else $error("match reported outside the search space or on a rejected item");

  a_reject_needs_space: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && reject_r) |-> in_space_r)
    else $error("reserved reject outside the search space");

  a_reply_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !matched_r) |-> (reply_r == '0))
    else $error("reply event not zero without a match");
`endif

endmodule
